// ===== hw/rtl/bsl_pkg.sv =====
`default_nettype none

package bsl_pkg;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_SEARCH = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_DUMP   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_POS   = 3'd4;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name;
    logic [15:0]        cls;
  } rec_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_CHK   = 8'b0000_0100,
    S_DEL   = 8'b0000_1000,
    S_INS   = 8'b0001_0000,
    S_PUT   = 8'b0010_0000,
    S_DUMP  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_sequential_list_unit.sv =====
`default_nettype none
// Append, insert at the end and errors found before any walk go from S_START to S_EMIT,
// which loads the registered result once the output slot is free. Search and remove walk
// the list from the record memory, one entry a cycle; remove and insert then move one entry
// a cycle through the same memory port pair. Dump gives one record a cycle while the output
// is taken. One item is worked at a time.
// Reset (rst, synchronous) empties the list and clears control; record contents are not reset.

module bounded_sequential_list_unit #(
  parameter int LIST_DEPTH = 8
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [2:0]         command,
  input  wire  signed [31:0] key,
  input  wire  [63:0]        name_chars,
  input  wire  [15:0]        class_number,
  input  wire  [3:0]         position,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [2:0]         status,
  output logic [2:0]         index,
  output logic signed [31:0] key_out,
  output logic [63:0]        name_out,
  output logic [15:0]        class_out,
  output logic [3:0]         count,
  output logic               last
);
  import bsl_pkg::*;

  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int PCW = (CW > 4) ? CW : 4;

  state_t state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] ptr_inc;
  logic [CW:0]   ptr_inc2;

  logic [2:0] op;
  rec_t       item_rec;
  logic [3:0] item_pos;

  logic [2:0] res_status, res_status_next;
  logic [2:0] res_index, res_index_next;
  rec_t       res_rec, res_rec_next;

  rec_t            mem [LIST_DEPTH];
  rec_t            rd_data;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  rec_t            wr_data;

  logic       slot_free, load_out;
  logic [2:0] ld_status, ld_index;
  rec_t       ld_rec;
  logic       ld_last;
  logic       accept, is_full, pos_bad;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign ptr_inc   = ptr + 1'b1;
  assign ptr_inc2  = {1'b0, ptr} + (CW + 1)'(2);
  assign is_full   = (fill == CW'(LIST_DEPTH));
  assign pos_bad   = PCW'(item_pos) > PCW'(fill);

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    ptr_next        = ptr;
    res_status_next = res_status;
    res_index_next  = res_index;
    res_rec_next    = res_rec;
    rd_en           = 1'b0;
    rd_addr         = ptr[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = ptr[AW-1:0];
    wr_data         = rd_data;
    load_out        = 1'b0;
    ld_status       = res_status;
    ld_index        = res_index;
    ld_rec          = res_rec;
    ld_last         = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_START;
        end
      end
      S_START: begin
        res_status_next = ST_OK;
        res_index_next  = '0;
        res_rec_next    = '0;
        ptr_next        = '0;
        rd_addr         = '0;
        state_next      = S_EMIT;
        priority if (op == CMD_APPEND || op == CMD_INSERT) begin
          if (is_full) begin
            res_status_next = ST_FULL;
          end else if (op == CMD_INSERT && pos_bad) begin
            res_status_next = ST_BAD_POS;
          end else if (op == CMD_APPEND || PCW'(item_pos) == PCW'(fill)) begin
            wr_en     = 1'b1;
            wr_addr   = fill[AW-1:0];
            wr_data   = item_rec;
            fill_next = fill + 1'b1;
          end else begin
            // move the tail up, starting from the top entry
            ptr_next   = fill;
            rd_en      = 1'b1;
            rd_addr    = AW'(fill - 1'b1);
            state_next = S_INS;
          end
        end else if (op == CMD_SEARCH || op == CMD_REMOVE || op == CMD_DUMP) begin
          if (fill == '0) begin
            res_status_next = (op == CMD_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            state_next = (op == CMD_DUMP) ? S_DUMP : S_CHK;
          end
        end else begin
          // undefined command: drop it
          state_next = S_IDLE;
        end
      end
      S_CHK: begin
        if (rd_data.key == item_rec.key) begin
          if (op == CMD_SEARCH) begin
            res_index_next = 3'(ptr);
            res_rec_next   = rd_data;
            state_next     = S_EMIT;
          end else if (ptr_inc >= fill) begin
            fill_next  = fill - 1'b1;
            state_next = S_EMIT;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = ptr_inc[AW-1:0];
            state_next = S_DEL;
          end
        end else if (ptr_inc >= fill) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_EMIT;
        end else begin
          ptr_next = ptr_inc;
          rd_en    = 1'b1;
          rd_addr  = ptr_inc[AW-1:0];
        end
      end
      S_DEL: begin
        // rd_data holds entry ptr+1: close the gap at ptr
        wr_en    = 1'b1;
        ptr_next = ptr_inc;
        if (ptr_inc2 < {1'b0, fill}) begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc2[AW-1:0];
        end else begin
          fill_next  = fill - 1'b1;
          state_next = S_EMIT;
        end
      end
      S_INS: begin
        // rd_data holds entry ptr-1: move it up to ptr
        wr_en    = 1'b1;
        ptr_next = ptr - 1'b1;
        if (PCW'(ptr - 1'b1) > PCW'(item_pos)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(ptr - CW'(2));
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = AW'(item_pos);
        wr_data    = item_rec;
        fill_next  = fill + 1'b1;
        state_next = S_EMIT;
      end
      S_DUMP: begin
        ld_status = ST_OK;
        ld_index  = 3'(ptr);
        ld_rec    = rd_data;
        ld_last   = (ptr_inc == fill);
        if (slot_free) begin
          load_out = 1'b1;
          if (ptr_inc == fill) begin
            state_next = S_IDLE;
          end else begin
            ptr_next = ptr_inc;
            rd_en    = 1'b1;
            rd_addr  = ptr_inc[AW-1:0];
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_rec    <= res_rec_next;
    if (accept) begin
      op            <= command;
      item_rec.key  <= key;
      item_rec.name <= name_chars;
      item_rec.cls  <= class_number;
      item_pos      <= position;
    end
    if (load_out) begin
      status    <= ld_status;
      index     <= ld_index;
      key_out   <= ld_rec.key;
      name_out  <= ld_rec.name;
      class_out <= ld_rec.cls;
      count     <= 4'(fill_next);
      last      <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(LIST_DEPTH))
    else $error("record count beyond list depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill != $past(fill)) |->
      (fill == $past(fill) + 1'b1 || fill == $past(fill) - 1'b1))
    else $error("record count moved by more than one");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write to the same entry in one cycle");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!wr_en && !rd_en && !load_out))
    else $error("memory or output activity while idle");

endmodule

`default_nettype wire

// ===== sim/bounded_sequential_list_unit_tb.sv =====
module bounded_sequential_list_unit_tb;
  import bsl_pkg::*;

  localparam int DEPTH = 8;
  localparam int RANDOM_ITEMS = 370;
  localparam int TAIL_CYCLES = 2 * DEPTH + 24;
  localparam int LONG_HOLD = 400;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic [63:0]        name;
    logic [15:0]        cls;
    logic [3:0]         pos;
    logic               drain;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         index;
    logic signed [31:0] key;
    logic [63:0]        name;
    logic [15:0]        cls;
    logic [3:0]         count;
    logic               last;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         command = '0;
  logic signed [31:0] key = '0;
  logic [63:0]        name_chars = '0;
  logic [15:0]        class_number = '0;
  logic [3:0]         position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic [2:0]         index;
  logic signed [31:0] key_out;
  logic [63:0]        name_out;
  logic [15:0]        class_out;
  logic [3:0]         count;
  logic               last;

  bounded_sequential_list_unit #(.LIST_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .key(key), .name_chars(name_chars),
    .class_number(class_number), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .index(index), .key_out(key_out), .name_out(name_out),
    .class_out(class_out), .count(count), .last(last)
  );

  // list shadow
  logic signed [31:0] rec_key [DEPTH];
  logic [63:0]        rec_name [DEPTH];
  logic [15:0]        rec_cls [DEPTH];
  int                 rec_count = 0;

  list_result_t result_queue[$];
  cmd_item_t    pending_items[$];
  cmd_item_t    on_offer;
  list_result_t got, want;

  int  errors = 0;
  int  results_seen = 0;
  int  cmd_seen [8];
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  int  rx_taken = 0;
  int  next_long_hold = 40;
  int  long_holds = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void post_result(logic [2:0] st, int idx, logic signed [31:0] k,
                                      logic [63:0] nm, logic [15:0] c, bit fin);
    list_result_t r;
    r.status = st;
    r.index  = 3'(idx);
    r.key    = k;
    r.name   = nm;
    r.cls    = c;
    r.count  = 4'(rec_count);
    r.last   = fin;
    result_queue.push_back(r);
  endfunction

  function automatic int find_first(logic signed [31:0] k);
    for (int i = 0; i < rec_count; i++)
      if (rec_key[i] == k) return i;
    return -1;
  endfunction

  // work out the results of one accepted item and update the shadow list
  function automatic void apply_command(cmd_item_t it);
    int at;
    case (it.cmd)
      CMD_APPEND: begin
        if (rec_count >= DEPTH) begin
          post_result(ST_FULL, 0, '0, '0, '0, 1'b1);
        end else begin
          rec_key[rec_count]  = it.key;
          rec_name[rec_count] = it.name;
          rec_cls[rec_count]  = it.cls;
          rec_count++;
          post_result(ST_OK, 0, '0, '0, '0, 1'b1);
        end
      end
      CMD_INSERT: begin
        if (rec_count >= DEPTH) begin
          post_result(ST_FULL, 0, '0, '0, '0, 1'b1);
        end else if (int'(it.pos) > rec_count) begin
          post_result(ST_BAD_POS, 0, '0, '0, '0, 1'b1);
        end else begin
          for (int i = rec_count; i > int'(it.pos); i--) begin
            rec_key[i]  = rec_key[i-1];
            rec_name[i] = rec_name[i-1];
            rec_cls[i]  = rec_cls[i-1];
          end
          rec_key[it.pos]  = it.key;
          rec_name[it.pos] = it.name;
          rec_cls[it.pos]  = it.cls;
          rec_count++;
          post_result(ST_OK, 0, '0, '0, '0, 1'b1);
        end
      end
      CMD_SEARCH: begin
        at = find_first(it.key);
        if (at < 0) post_result(ST_NOT_FOUND, 0, '0, '0, '0, 1'b1);
        else post_result(ST_OK, at, rec_key[at], rec_name[at], rec_cls[at], 1'b1);
      end
      CMD_REMOVE: begin
        at = find_first(it.key);
        if (rec_count == 0) begin
          post_result(ST_EMPTY, 0, '0, '0, '0, 1'b1);
        end else if (at < 0) begin
          post_result(ST_NOT_FOUND, 0, '0, '0, '0, 1'b1);
        end else begin
          for (int i = at; i + 1 < rec_count; i++) begin
            rec_key[i]  = rec_key[i+1];
            rec_name[i] = rec_name[i+1];
            rec_cls[i]  = rec_cls[i+1];
          end
          rec_count--;
          post_result(ST_OK, 0, '0, '0, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (rec_count == 0) post_result(ST_EMPTY, 0, '0, '0, '0, 1'b1);
        else
          for (int i = 0; i < rec_count; i++)
            post_result(ST_OK, i, rec_key[i], rec_name[i], rec_cls[i], i == rec_count - 1);
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(logic [2:0] op, logic signed [31:0] k, logic [63:0] nm,
                                     logic [15:0] c, logic [3:0] p, bit drain);
    cmd_item_t it;
    it.cmd   = op;
    it.key   = k;
    it.name  = nm;
    it.cls   = c;
    it.pos   = p;
    it.drain = drain;
    pending_items.push_back(it);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_command(on_offer);
        cmd_seen[on_offer.cmd]++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && result_queue.size() != 0)) begin
          on_offer = pending_items.pop_front();
          command      <= on_offer.cmd;
          key          <= on_offer.key;
          name_chars   <= on_offer.name;
          class_number <= on_offer.cls;
          position     <= on_offer.pos;
          in_valid     <= 1'b1;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          tx_gap = pick_gap(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: short random stalls, plus a long hold now and then
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_taken++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_taken >= next_long_hold) begin
        hold_left = LONG_HOLD;
        next_long_hold += 300;
        long_holds++;
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        if (out_valid && out_ready) begin
          if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
          rx_gap = pick_gap(rx_calm);
        end
        out_ready <= (rx_gap == 0);
      end
    end
  end

  // checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {status, index, key_out, name_out, class_out, count, last};
      results_seen++;
      if (result_queue.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected result st=%0d idx=%0d key=%h name=%h cls=%h cnt=%0d last=%b",
                   $time, got.status, got.index, got.key, got.name, got.cls, got.count,
                   got.last);
      end else begin
        want = result_queue.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 50) begin
            $display("%0t: expected st=%0d idx=%0d key=%h name=%h cls=%h cnt=%0d last=%b",
                     $time, want.status, want.index, want.key, want.name, want.cls,
                     want.count, want.last);
            $display("%0t: actual   st=%0d idx=%0d key=%h name=%h cls=%h cnt=%0d last=%b",
                     $time, got.status, got.index, got.key, got.name, got.cls, got.count,
                     got.last);
          end
        end
      end
    end
  end

  initial begin
    int                 roll, pick;
    logic [2:0]         op;
    logic signed [31:0] k;
    logic [3:0]         p;
    logic signed [31:0] key_pool [6];

    for (int i = 0; i < 6; i++) key_pool[i] = $urandom;

    // empty-list errors and bad position
    queue_item(CMD_DUMP,   0, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_SEARCH, 0, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_REMOVE, 0, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_INSERT, 7, '1, '1, 4'd1, 1'b0);
    // field extremes, duplicate key ahead of its twin
    queue_item(CMD_INSERT, 32'sh8000_0000, '1, '1, 4'd0, 1'b0);
    queue_item(CMD_APPEND, 32'sh7fff_ffff, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_APPEND, 5, 64'h414c_4943_4500_0000, 16'd101, 4'd0, 1'b0);
    queue_item(CMD_INSERT, 5, 64'h424f_4200_0000_0000, 16'd202, 4'd1, 1'b0);
    queue_item(CMD_INSERT, 9, '0, '0, 4'd15, 1'b0);
    queue_item(CMD_SEARCH, 5, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_REMOVE, 99, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_REMOVE, 5, '0, '0, 4'd0, 1'b0);
    for (int i = -1; i < 4; i++)
      queue_item(CMD_APPEND, i, {$urandom, $urandom}, 16'($urandom), 4'd0, 1'b0);
    // full list
    queue_item(CMD_APPEND, 77, '1, '1, 4'd0, 1'b0);
    queue_item(CMD_INSERT, 78, '1, '1, 4'd12, 1'b0);
    queue_item(CMD_DUMP,   0, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_SEARCH, 3, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_REMOVE, 32'sh8000_0000, '0, '0, 4'd0, 1'b0);
    queue_item(CMD_INSERT, 42, 64'h0123_4567_89ab_cdef, 16'h8001, 4'd7, 1'b0);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      queue_item(3'(c), '1, '1, '1, 4'd15, 1'b0);
    queue_item(CMD_DUMP,   0, '0, '0, 4'd0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) op = CMD_APPEND;
      else if (roll < 40) op = CMD_INSERT;
      else if (roll < 60) op = CMD_SEARCH;
      else if (roll < 88) op = CMD_REMOVE;
      else if (roll < 97) op = CMD_DUMP;
      else op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(0, 5)] = $urandom;
      // keys mostly from a small pool so that searches and removes hit
      pick = $urandom_range(0, 99);
      if (pick < 75) k = key_pool[$urandom_range(0, 5)];
      else if (pick < 90) k = $urandom;
      else k = pick[0] ? 32'sh7fff_ffff : 32'sh8000_0000;
      p = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, DEPTH)) : 4'($urandom_range(0, 15));
      queue_item(op, k, {$urandom, $urandom}, 16'($urandom), p, n % 100 == 0);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || result_queue.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (result_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, result_queue.size());
    end
    $display("Covered %0d appends, %0d inserts, %0d searches, %0d removes, %0d dumps,",
             cmd_seen[CMD_APPEND], cmd_seen[CMD_INSERT], cmd_seen[CMD_SEARCH],
             cmd_seen[CMD_REMOVE], cmd_seen[CMD_DUMP]);
    $display("%0d ignored codes; %0d results checked, %0d long output holds, %0d errors",
             cmd_seen[5] + cmd_seen[6] + cmd_seen[7], results_seen, long_holds, errors);
    if (errors == 0) begin
      $display("[bounded_sequential_list_unit] OK");
    end else begin
      $display("[bounded_sequential_list_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[bounded_sequential_list_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bsl_pkg.sv
hw/rtl/bounded_sequential_list_unit.sv
sim/bounded_sequential_list_unit_tb.sv
